[rtl/core/hvf_pkg.sv]
`default_nettype none

package hvf_pkg;

	localparam int unsigned GAIN_W   = 32;
	localparam int unsigned EAG_W    = 24;
	localparam int unsigned DPC_W    = 20;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned ANGLE_W  = 32;
	localparam int unsigned SPEED_W  = 16;
	localparam int unsigned MAC_A_W  = 33;
	localparam int unsigned MAC_B_W  = 21;
	localparam int unsigned ACC_W    = 64;
	localparam int unsigned NUM_W    = 57;
	localparam int unsigned QUO_W    = 17;
	localparam int unsigned DIV_STEPS = QUO_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] REG_GYRO_GAIN   = 2'd0;
	localparam logic [1:0] REG_ENC_GAIN    = 2'd1;
	localparam logic [1:0] REG_DIST_COUNT  = 2'd2;
	localparam logic [1:0] REG_GYRO_WEIGHT = 2'd3;

	localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST   = 32'd3202559782;
	localparam logic [EAG_W-1:0]    ENC_GAIN_RST    = 24'd1000000;
	localparam logic [DPC_W-1:0]    DIST_COUNT_RST  = 20'd9000;
	localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RST = 17'd64225;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'd65536;

	localparam logic [MAC_A_W-1:0] US_PER_S    = 33'd1000000;
	localparam logic [MAC_A_W-1:0] GYRO_ROUND  = 33'h0_8000_0000;
	localparam logic [MAC_A_W-1:0] MIX_ROUND   = 33'd32768;
	localparam logic [MAC_B_W-1:0] HALF_DEN    = 21'd65536;
	localparam logic [MAC_B_W-1:0] MAC_UNIT    = 21'd1;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		STEP_RATE_DT,
		STEP_GAIN_HI,
		STEP_GAIN_LO,
		STEP_GYRO_RND,
		STEP_ENC,
		STEP_MIX_GYRO,
		STEP_MIX_ENC,
		STEP_MIX_RND,
		STEP_DIST,
		STEP_US_HI,
		STEP_US_LO,
		STEP_HALF_DEN
	} step_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_16,
		SH_20
	} sh_t;

	typedef struct packed {
		logic                      valid;
		logic                      clr;
		sh_t                       sh;
		logic signed [MAC_A_W-1:0] a;
		logic signed [MAC_B_W-1:0] b;
	} mac_op_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [15:0]       dt;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUO_W-1:0]  quo;
	} div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/hvf_mac.sv]
`default_nettype none

module hvf_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hvf_pkg::mac_op_t                      op,
	output logic signed [hvf_pkg::ACC_W-1:0]      acc
);

	localparam int unsigned PROD_W = hvf_pkg::MAC_A_W + hvf_pkg::MAC_B_W;

	logic                            vld_s1;
	logic                            clr_s1;
	hvf_pkg::sh_t                    sh_s1;
	logic signed [PROD_W-1:0]        prod_s1;
	logic signed [hvf_pkg::ACC_W-1:0] acc_q;
	logic signed [hvf_pkg::ACC_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.valid;
		end
	end

	always_comb begin
		base = acc_q;
		if (clr_s1) begin
			base = '0;
		end else begin
			case (sh_s1)
				hvf_pkg::SH_16: base = acc_q <<< 16;
				hvf_pkg::SH_20: base = acc_q <<< 20;
				default:        base = acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op.valid) begin
			prod_s1 <= op.a * op.b;
			clr_s1  <= op.clr;
			sh_s1   <= op.sh;
		end
		if (vld_s1) begin
			acc_q <= base + hvf_pkg::ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

[rtl/core/hvf_div.sv]
`default_nettype none

module hvf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  hvf_pkg::div_req_t   req,
	output hvf_pkg::div_rsp_t   rsp
);

	localparam int unsigned DSR_W = 16 + 33;

	logic                           busy_q;
	logic                           done_q;
	logic [hvf_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [hvf_pkg::NUM_W-1:0]      rem_q;
	logic [DSR_W-1:0]               dsr_q;
	logic [hvf_pkg::QUO_W-1:0]      quo_q;
	logic [hvf_pkg::NUM_W-1:0]      dsr_ext;
	logic                           ge;

	assign dsr_ext = hvf_pkg::NUM_W'(dsr_q);
	assign ge      = rem_q >= dsr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == hvf_pkg::DIV_CNT_W'(hvf_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsr_q <= {req.dt, 33'b0};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_ext;
			end
			quo_q <= {quo_q[hvf_pkg::QUO_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

[rtl/core/heading_velocity_fusion.sv]
`default_nettype none

// Gyro and wheel-encoder heading and speed fusion. Each input transaction is
// either an update tick (tuser 0) or a heading reset (tuser 1). An update
// runs twelve multiply-accumulate steps on one shared 33x21-bit multiplier
// with a 64-bit accumulator, and then a restoring divider for the speed,
// after which the result passes through the done state into the output
// register. A heading reset goes from acceptance straight to the done state
// and then into the output register. The block takes one item at a time;
// the input is ready again once the result is in the output register, even
// while it waits to be taken.
module heading_velocity_fusion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// gyro_rate[15:0], left_counts[31:16], right_counts[47:32],
	// elapsed_us[63:48], preset_heading[95:64]
	input  logic [95:0] s_axis_tdata,
	// command[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// heading[31:0], velocity[47:32]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	hvf_pkg::state_t state_q, state_d;
	hvf_pkg::step_t  step_q, step_d;
	logic            phase_q, phase_d;

	logic [hvf_pkg::GAIN_W-1:0]   gyro_gain_q;
	logic [hvf_pkg::EAG_W-1:0]    enc_gain_q;
	logic [hvf_pkg::DPC_W-1:0]    dist_count_q;
	logic [hvf_pkg::WEIGHT_W-1:0] gyro_weight_q;

	logic [hvf_pkg::ANGLE_W-1:0] gy_q;
	logic [hvf_pkg::ANGLE_W-1:0] ey_q;
	logic [hvf_pkg::ANGLE_W-1:0] fused_q;
	logic [hvf_pkg::SPEED_W-1:0] speed_q;

	logic signed [15:0] rate_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic [15:0]        dt_q;
	logic [31:0]        p1_q;
	logic [19:0]        m_lo_q;

	logic [hvf_pkg::ANGLE_W-1:0] out_heading_q;
	logic [hvf_pkg::SPEED_W-1:0] out_velocity_q;
	logic                        m_valid_q;

	logic signed [16:0] diff;
	logic signed [16:0] sum;
	logic [16:0]        mag;
	logic               neg;
	logic [hvf_pkg::WEIGHT_W-1:0] w;
	logic [hvf_pkg::WEIGHT_W-1:0] wc;

	logic signed [hvf_pkg::ACC_W-1:0] acc;
	hvf_pkg::mac_op_t  mac_op;
	hvf_pkg::div_req_t div_req;
	hvf_pkg::div_rsp_t div_rsp;

	logic accept;
	logic out_load;
	logic issue;
	logic [hvf_pkg::SPEED_W-1:0] speed_new;

	assign accept = s_axis_tvalid && s_axis_tready;

	assign diff = 17'(right_q) - 17'(left_q);
	assign sum  = 17'(right_q) + 17'(left_q);
	assign neg  = sum[16];
	assign mag  = neg ? 17'(-sum) : 17'(sum);
	assign w    = (gyro_weight_q > hvf_pkg::WEIGHT_ONE) ? hvf_pkg::WEIGHT_ONE : gyro_weight_q;
	assign wc   = hvf_pkg::WEIGHT_ONE - w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvf_pkg::ST_IDLE;
			step_q  <= hvf_pkg::STEP_RATE_DT;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		phase_d       = phase_q;
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = acc[hvf_pkg::NUM_W-1:0];
		div_req.dt    = dt_q;
		out_load      = 1'b0;
		case (state_q)
			hvf_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					step_d  = hvf_pkg::STEP_RATE_DT;
					phase_d = 1'b0;
					state_d = s_axis_tuser[0] ? hvf_pkg::ST_DONE : hvf_pkg::ST_MAC;
				end
			end
			hvf_pkg::ST_MAC: begin
				phase_d = !phase_q;
				if (!phase_q) begin
					issue = 1'b1;
				end else begin
					case (step_q)
						hvf_pkg::STEP_RATE_DT:  step_d = hvf_pkg::STEP_GAIN_HI;
						hvf_pkg::STEP_GAIN_HI:  step_d = hvf_pkg::STEP_GAIN_LO;
						hvf_pkg::STEP_GAIN_LO:  step_d = hvf_pkg::STEP_GYRO_RND;
						hvf_pkg::STEP_GYRO_RND: step_d = hvf_pkg::STEP_ENC;
						hvf_pkg::STEP_ENC:      step_d = hvf_pkg::STEP_MIX_GYRO;
						hvf_pkg::STEP_MIX_GYRO: step_d = hvf_pkg::STEP_MIX_ENC;
						hvf_pkg::STEP_MIX_ENC:  step_d = hvf_pkg::STEP_MIX_RND;
						hvf_pkg::STEP_MIX_RND:  step_d = hvf_pkg::STEP_DIST;
						hvf_pkg::STEP_DIST:     step_d = hvf_pkg::STEP_US_HI;
						hvf_pkg::STEP_US_HI:    step_d = hvf_pkg::STEP_US_LO;
						hvf_pkg::STEP_US_LO:    step_d = hvf_pkg::STEP_HALF_DEN;
						default: begin
							step_d  = hvf_pkg::STEP_RATE_DT;
							state_d = hvf_pkg::ST_LOAD;
						end
					endcase
				end
			end
			hvf_pkg::ST_LOAD: begin
				div_req.start = 1'b1;
				state_d       = hvf_pkg::ST_DIV;
			end
			hvf_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = hvf_pkg::ST_DONE;
				end
			end
			hvf_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = hvf_pkg::ST_IDLE;
				end
			end
			default: state_d = hvf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mac_op.valid = issue;
		mac_op.clr   = 1'b0;
		mac_op.sh    = hvf_pkg::SH_NONE;
		mac_op.a     = '0;
		mac_op.b     = '0;
		case (step_q)
			hvf_pkg::STEP_RATE_DT: begin
				mac_op.clr = 1'b1;
				mac_op.a   = 33'(rate_q);
				mac_op.b   = {5'b0, dt_q};
			end
			hvf_pkg::STEP_GAIN_HI: begin
				mac_op.clr = 1'b1;
				mac_op.a   = {acc[31], acc[31:0]};
				mac_op.b   = {5'b0, gyro_gain_q[31:16]};
			end
			hvf_pkg::STEP_GAIN_LO: begin
				mac_op.sh = hvf_pkg::SH_16;
				mac_op.a  = {p1_q[31], p1_q};
				mac_op.b  = {5'b0, gyro_gain_q[15:0]};
			end
			hvf_pkg::STEP_GYRO_RND: begin
				mac_op.a = hvf_pkg::GYRO_ROUND;
				mac_op.b = hvf_pkg::MAC_UNIT;
			end
			hvf_pkg::STEP_ENC: begin
				mac_op.clr = 1'b1;
				mac_op.a   = {9'b0, enc_gain_q};
				mac_op.b   = 21'(diff);
			end
			hvf_pkg::STEP_MIX_GYRO: begin
				mac_op.clr = 1'b1;
				mac_op.a   = {gy_q[31], gy_q};
				mac_op.b   = {4'b0, w};
			end
			hvf_pkg::STEP_MIX_ENC: begin
				mac_op.a = {ey_q[31], ey_q};
				mac_op.b = {4'b0, wc};
			end
			hvf_pkg::STEP_MIX_RND: begin
				mac_op.a = hvf_pkg::MIX_ROUND;
				mac_op.b = hvf_pkg::MAC_UNIT;
			end
			hvf_pkg::STEP_DIST: begin
				mac_op.clr = 1'b1;
				mac_op.a   = {16'b0, mag};
				mac_op.b   = {1'b0, dist_count_q};
			end
			hvf_pkg::STEP_US_HI: begin
				mac_op.clr = 1'b1;
				mac_op.a   = hvf_pkg::US_PER_S;
				mac_op.b   = {4'b0, acc[36:20]};
			end
			hvf_pkg::STEP_US_LO: begin
				mac_op.sh = hvf_pkg::SH_20;
				mac_op.a  = hvf_pkg::US_PER_S;
				mac_op.b  = {1'b0, m_lo_q};
			end
			hvf_pkg::STEP_HALF_DEN: begin
				mac_op.a = {17'b0, dt_q};
				mac_op.b = hvf_pkg::HALF_DEN;
			end
			default: mac_op.valid = issue;
		endcase
	end

	always_comb begin
		if (neg) begin
			if (div_rsp.quo[16] || (div_rsp.quo[15:0] > hvf_pkg::SPEED_MIN)) begin
				speed_new = hvf_pkg::SPEED_MIN;
			end else begin
				speed_new = 16'(~div_rsp.quo[15:0] + 16'd1);
			end
		end else begin
			if (div_rsp.quo[16] || (div_rsp.quo[15:0] > hvf_pkg::SPEED_MAX)) begin
				speed_new = hvf_pkg::SPEED_MAX;
			end else begin
				speed_new = div_rsp.quo[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q   <= hvf_pkg::GYRO_GAIN_RST;
			enc_gain_q    <= hvf_pkg::ENC_GAIN_RST;
			dist_count_q  <= hvf_pkg::DIST_COUNT_RST;
			gyro_weight_q <= hvf_pkg::GYRO_WEIGHT_RST;
			gy_q          <= '0;
			ey_q          <= '0;
			fused_q       <= '0;
			speed_q       <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hvf_pkg::REG_GYRO_GAIN:   gyro_gain_q   <= cfg_data;
					hvf_pkg::REG_ENC_GAIN:    enc_gain_q    <= cfg_data[23:0];
					hvf_pkg::REG_DIST_COUNT:  dist_count_q  <= cfg_data[19:0];
					hvf_pkg::REG_GYRO_WEIGHT: gyro_weight_q <= cfg_data[16:0];
					default: gyro_weight_q <= gyro_weight_q;
				endcase
			end
			if (accept && s_axis_tuser[0]) begin
				gy_q    <= s_axis_tdata[95:64];
				ey_q    <= s_axis_tdata[95:64];
				fused_q <= s_axis_tdata[95:64];
			end
			if (issue) begin
				case (step_q)
					hvf_pkg::STEP_ENC:      gy_q    <= gy_q + acc[63:32];
					hvf_pkg::STEP_MIX_GYRO: ey_q    <= ey_q + acc[31:0];
					hvf_pkg::STEP_DIST:     fused_q <= acc[47:16];
					default:                fused_q <= fused_q;
				endcase
			end
			if ((state_q == hvf_pkg::ST_DIV) && div_rsp.done && (dt_q != 16'd0)) begin
				speed_q <= speed_new;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rate_q  <= s_axis_tdata[15:0];
			left_q  <= s_axis_tdata[31:16];
			right_q <= s_axis_tdata[47:32];
			dt_q    <= s_axis_tdata[63:48];
		end
		if (issue && (step_q == hvf_pkg::STEP_GAIN_HI)) begin
			p1_q <= acc[31:0];
		end
		if (issue && (step_q == hvf_pkg::STEP_US_HI)) begin
			m_lo_q <= acc[19:0];
		end
		if (out_load) begin
			out_heading_q  <= fused_q;
			out_velocity_q <= speed_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_velocity_q, out_heading_q};

	hvf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	hvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == hvf_pkg::ST_DIV)
		else $error("divider result outside the divide state");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == hvf_pkg::ST_DONE)
		else $error("output raised outside the done state");

	a_reset_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser[0]) |=>
			(state_q == hvf_pkg::ST_DONE) && (fused_q == $past(s_axis_tdata[95:64])))
		else $error("heading reset not applied");

	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == hvf_pkg::ST_DIV) && div_rsp.done && (dt_q == 16'd0)) |=>
			$stable(speed_q))
		else $error("speed changed on a zero time step");

	a_no_issue_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !mac_op.valid && (state_q == hvf_pkg::ST_DIV))
		else $error("multiply issued while dividing");

endmodule

`default_nettype wire
